### hw/rtl/xmpp_address_validator_top_assert.svh
// ----------------------------------------------------------------------------
// xmpp address validator assertion macros
// concurrent checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef XMPP_ADDRESS_VALIDATOR_TOP_ASSERT_SVH
`define XMPP_ADDRESS_VALIDATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define XAV_ASSERT_IMP(lbl, clk, rst, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
        else $error("xav assertion failed");

// next-cycle implication
`define XAV_ASSERT_NXT(lbl, clk, rst, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
        else $error("xav assertion failed");

`else

`define XAV_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define XAV_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

### hw/rtl/xav_pkg.sv
// ----------------------------------------------------------------------------
// xav_pkg
// limits, widths, codes and character classes of the address validator
// ----------------------------------------------------------------------------
package xav_pkg;

    localparam int MAX_NODE_UNITS     = 256;
    localparam int MAX_DOMAIN_UNITS   = 255;
    localparam int MIN_DOMAIN_UNITS   = 2;
    localparam int MAX_RESOURCE_UNITS = 256;

    // counters saturate one step above their limit
    localparam int NODE_CAP   = MAX_NODE_UNITS + 1;
    localparam int DOMAIN_CAP = MAX_DOMAIN_UNITS + 1;
    localparam int RES_CAP    = MAX_RESOURCE_UNITS + 1;
    localparam int PREFIX_CAP = (NODE_CAP > DOMAIN_CAP) ? NODE_CAP : DOMAIN_CAP;

    localparam int PREFIX_W = $clog2(PREFIX_CAP + 1);
    localparam int NODE_W   = $clog2(NODE_CAP + 1);
    localparam int DOM_W    = $clog2(DOMAIN_CAP + 1);
    localparam int RES_W    = $clog2(RES_CAP + 1);

    localparam int CODE_W      = 16;
    localparam int ERR_W       = 4;
    localparam int NODE_LEN_W  = 9;
    localparam int DOM_LEN_W   = 8;
    localparam int RES_LEN_W   = 9;

    localparam logic [CODE_W-1:0] CH_AT    = 16'h0040;
    localparam logic [CODE_W-1:0] CH_SLASH = 16'h002F;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK         = 4'd0,
        ERR_EMPTY      = 4'd1,
        ERR_NODE_LONG  = 4'd2,
        ERR_NODE_CHAR  = 4'd3,
        ERR_DOM_SHORT  = 4'd4,
        ERR_DOM_LONG   = 4'd5,
        ERR_DOM_CHAR   = 4'd6,
        ERR_RES_LONG   = 4'd7,
        ERR_RES_CHAR   = 4'd8
    } err_t;

    typedef enum logic [3:0] {
        PH_PREFIX     = 4'b0001,
        PH_DOMAIN     = 4'b0010,
        PH_RES_NONODE = 4'b0100,
        PH_RES_NODE   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic                  valid_res;
        err_t                  error_code;
        logic                  has_node;
        logic [NODE_LEN_W-1:0] node_length;
        logic [DOM_LEN_W-1:0]  domain_length;
        logic                  has_resource;
        logic [RES_LEN_W-1:0]  resource_length;
    } verdict_t;

    function automatic logic node_unit_ok(input logic [CODE_W-1:0] c);
        logic ok;
        ok = 1'b1;
        if (c <= 16'h0020)
            ok = 1'b0;
        case (c) inside
            16'h0022, 16'h0026, 16'h0027, 16'h002F,
            16'h003A, 16'h003C, 16'h003E, 16'h0040,
            16'h007F, 16'hFFFE, 16'hFFFF: ok = 1'b0;
            default: ;
        endcase
        return ok;
    endfunction

    function automatic logic domain_unit_ok(input logic [CODE_W-1:0] c);
        return (c >= 16'h0041 && c <= 16'h005A) || (c >= 16'h0061 && c <= 16'h007A) ||
               (c >= 16'h0030 && c <= 16'h0039) || c == 16'h002D || c == 16'h002E;
    endfunction

    function automatic logic resource_unit_ok(input logic [CODE_W-1:0] c);
        return c >= 16'h0020 && c < 16'hFFFE;
    endfunction

endpackage

### hw/rtl/xav_unit_if.sv
// ----------------------------------------------------------------------------
// xav_unit_if
// code unit channel into the validator
// ----------------------------------------------------------------------------
interface xav_unit_if
    import xav_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] code_unit;
    logic              unit_present;
    logic              is_last;

    modport source (output valid, code_unit, unit_present, is_last, input ready);
    modport sink   (input valid, code_unit, unit_present, is_last, output ready);
endinterface

### hw/rtl/xav_verdict_if.sv
// ----------------------------------------------------------------------------
// xav_verdict_if
// verdict channel out of the validator
// ----------------------------------------------------------------------------
interface xav_verdict_if
    import xav_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic                  valid_res;
    logic [ERR_W-1:0]      error_code;
    logic                  has_node;
    logic [NODE_LEN_W-1:0] node_length;
    logic [DOM_LEN_W-1:0]  domain_length;
    logic                  has_resource;
    logic [RES_LEN_W-1:0]  resource_length;

    modport source (output valid, valid_res, error_code, has_node, node_length,
                    domain_length, has_resource, resource_length, input ready);
    modport sink   (input valid, valid_res, error_code, has_node, node_length,
                    domain_length, has_resource, resource_length, output ready);
endinterface

### hw/rtl/xmpp_address_validator_top.sv
// ----------------------------------------------------------------------------
// xmpp_address_validator_top
// streaming address validator: one code unit per transfer, one verdict per
// address on the transfer marked last
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  unit_ch   in   code_unit, unit_present, is_last
//  res_ch    out  valid_res, error_code, has_node, node_length,
//                 domain_length, has_resource, resource_length
//
//  one code unit per cycle while no verdict is stalled; a unit is registered,
//  then classified and counted in the next cycle; the last unit passes the
//  input register and then the result register before its verdict is offered
//  rst_n clears the handshake flags and the per-address state
//  a stalled verdict holds only a last unit in the input register; other
//  units keep flowing into the counters
// ----------------------------------------------------------------------------
`include "xmpp_address_validator_top_assert.svh"

module xmpp_address_validator_top
    import xav_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    xav_unit_if.sink         unit_ch,
    xav_verdict_if.source    res_ch
);

    // input register
    logic              s1_valid_reg;
    logic [CODE_W-1:0] s1_code_reg;
    logic              s1_present_reg;
    logic              s1_last_reg;

    // per-address state
    phase_t               phase_reg, phase_next;
    logic [PREFIX_W-1:0]  prefix_len_reg, prefix_len_next;
    logic                 prefix_node_clean_reg, prefix_node_clean_next;
    logic                 prefix_dom_clean_reg, prefix_dom_clean_next;
    logic [NODE_W-1:0]    node_cnt_reg, node_cnt_next;
    logic                 node_clean_reg, node_clean_next;
    logic [DOM_W-1:0]     dom_cnt_reg, dom_cnt_next;
    logic                 dom_clean_reg, dom_clean_next;
    logic [RES_W-1:0]     res_cnt_reg, res_cnt_next;
    logic                 res_clean_reg, res_clean_next;

    // result register
    logic     out_valid_reg;
    verdict_t verdict_reg, verdict_next;

    logic out_free;
    logic s1_fire;

    // state after taking in the current unit
    phase_t              u_phase;
    logic [PREFIX_W-1:0] u_prefix_len;
    logic                u_prefix_node_clean, u_prefix_dom_clean;
    logic [NODE_W-1:0]   u_node_cnt;
    logic                u_node_clean;
    logic [DOM_W-1:0]    u_dom_cnt;
    logic                u_dom_clean;
    logic [RES_W-1:0]    u_res_cnt;
    logic                u_res_clean;

    logic [DOM_W-1:0] f_dom_cnt;
    logic             f_dom_clean;
    logic             f_has_node;
    logic             f_has_res;
    logic             f_empty;
    err_t             f_err;

    assign out_free      = !out_valid_reg || res_ch.ready;
    assign s1_fire       = s1_valid_reg && (!s1_last_reg || out_free);
    assign unit_ch.ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (unit_ch.ready)
        begin
            s1_valid_reg <= unit_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (unit_ch.valid && unit_ch.ready)
        begin
            s1_code_reg    <= unit_ch.code_unit;
            s1_present_reg <= unit_ch.unit_present;
            s1_last_reg    <= unit_ch.is_last;
        end
    end

    // take in one unit
    always_comb
    begin
        u_phase             = phase_reg;
        u_prefix_len        = prefix_len_reg;
        u_prefix_node_clean = prefix_node_clean_reg;
        u_prefix_dom_clean  = prefix_dom_clean_reg;
        u_node_cnt          = node_cnt_reg;
        u_node_clean        = node_clean_reg;
        u_dom_cnt           = dom_cnt_reg;
        u_dom_clean         = dom_clean_reg;
        u_res_cnt           = res_cnt_reg;
        u_res_clean         = res_clean_reg;
        if (s1_present_reg)
        begin
            unique case (phase_reg) inside
                PH_PREFIX:
                begin
                    if (s1_code_reg == CH_SLASH)
                    begin
                        u_dom_cnt   = (32'(prefix_len_reg) > DOMAIN_CAP) ?
                                      DOM_W'(DOMAIN_CAP) : DOM_W'(prefix_len_reg);
                        u_dom_clean = prefix_dom_clean_reg;
                        u_phase     = PH_RES_NONODE;
                    end
                    else if (s1_code_reg == CH_AT)
                    begin
                        u_node_cnt   = (32'(prefix_len_reg) > NODE_CAP) ?
                                       NODE_W'(NODE_CAP) : NODE_W'(prefix_len_reg);
                        u_node_clean = prefix_node_clean_reg;
                        u_phase      = PH_DOMAIN;
                    end
                    else
                    begin
                        if (32'(prefix_len_reg) < PREFIX_CAP)
                            u_prefix_len = prefix_len_reg + PREFIX_W'(1);
                        u_prefix_node_clean = prefix_node_clean_reg &&
                                              node_unit_ok(s1_code_reg);
                        u_prefix_dom_clean  = prefix_dom_clean_reg &&
                                              domain_unit_ok(s1_code_reg);
                    end
                end
                PH_DOMAIN:
                begin
                    if (s1_code_reg == CH_SLASH)
                    begin
                        u_phase = PH_RES_NODE;
                    end
                    else
                    begin
                        if (32'(dom_cnt_reg) < DOMAIN_CAP)
                            u_dom_cnt = dom_cnt_reg + DOM_W'(1);
                        u_dom_clean = dom_clean_reg && domain_unit_ok(s1_code_reg);
                    end
                end
                PH_RES_NONODE, PH_RES_NODE:
                begin
                    // separators inside the resource are plain units
                    if (32'(res_cnt_reg) < RES_CAP)
                        u_res_cnt = res_cnt_reg + RES_W'(1);
                    u_res_clean = res_clean_reg && resource_unit_ok(s1_code_reg);
                end
                default: ;
            endcase
        end
    end

    // verdict on the updated state
    always_comb
    begin
        f_empty    = (u_phase == PH_PREFIX) && (u_prefix_len == '0);
        f_has_node = (u_phase == PH_DOMAIN) || (u_phase == PH_RES_NODE);
        f_has_res  = (u_phase == PH_RES_NONODE) || (u_phase == PH_RES_NODE);
        if (u_phase == PH_PREFIX)
        begin
            f_dom_cnt   = (32'(u_prefix_len) > DOMAIN_CAP) ?
                          DOM_W'(DOMAIN_CAP) : DOM_W'(u_prefix_len);
            f_dom_clean = u_prefix_dom_clean;
        end
        else
        begin
            f_dom_cnt   = u_dom_cnt;
            f_dom_clean = u_dom_clean;
        end

        if (f_empty)
            f_err = ERR_EMPTY;
        else if (f_has_node && 32'(u_node_cnt) > MAX_NODE_UNITS)
            f_err = ERR_NODE_LONG;
        else if (f_has_node && !u_node_clean)
            f_err = ERR_NODE_CHAR;
        else if (32'(f_dom_cnt) < MIN_DOMAIN_UNITS)
            f_err = ERR_DOM_SHORT;
        else if (32'(f_dom_cnt) > MAX_DOMAIN_UNITS)
            f_err = ERR_DOM_LONG;
        else if (!f_dom_clean)
            f_err = ERR_DOM_CHAR;
        else if (f_has_res && 32'(u_res_cnt) > MAX_RESOURCE_UNITS)
            f_err = ERR_RES_LONG;
        else if (f_has_res && !u_res_clean)
            f_err = ERR_RES_CHAR;
        else
            f_err = ERR_OK;

        verdict_next = '0;
        verdict_next.error_code = f_err;
        if (f_err == ERR_OK)
        begin
            verdict_next.valid_res       = 1'b1;
            verdict_next.has_node        = f_has_node;
            verdict_next.node_length     = f_has_node ? NODE_LEN_W'(u_node_cnt) : '0;
            verdict_next.domain_length   = DOM_LEN_W'(f_dom_cnt);
            verdict_next.has_resource    = f_has_res;
            verdict_next.resource_length = f_has_res ? RES_LEN_W'(u_res_cnt) : '0;
        end
    end

    // a verdict returns the state to its reset values
    always_comb
    begin
        phase_next             = phase_reg;
        prefix_len_next        = prefix_len_reg;
        prefix_node_clean_next = prefix_node_clean_reg;
        prefix_dom_clean_next  = prefix_dom_clean_reg;
        node_cnt_next          = node_cnt_reg;
        node_clean_next        = node_clean_reg;
        dom_cnt_next           = dom_cnt_reg;
        dom_clean_next         = dom_clean_reg;
        res_cnt_next           = res_cnt_reg;
        res_clean_next         = res_clean_reg;
        if (s1_fire)
        begin
            if (s1_last_reg)
            begin
                phase_next             = PH_PREFIX;
                prefix_len_next        = '0;
                prefix_node_clean_next = 1'b1;
                prefix_dom_clean_next  = 1'b1;
                node_cnt_next          = '0;
                node_clean_next        = 1'b1;
                dom_cnt_next           = '0;
                dom_clean_next         = 1'b1;
                res_cnt_next           = '0;
                res_clean_next         = 1'b1;
            end
            else
            begin
                phase_next             = u_phase;
                prefix_len_next        = u_prefix_len;
                prefix_node_clean_next = u_prefix_node_clean;
                prefix_dom_clean_next  = u_prefix_dom_clean;
                node_cnt_next          = u_node_cnt;
                node_clean_next        = u_node_clean;
                dom_cnt_next           = u_dom_cnt;
                dom_clean_next         = u_dom_clean;
                res_cnt_next           = u_res_cnt;
                res_clean_next         = u_res_clean;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg             <= PH_PREFIX;
            prefix_len_reg        <= '0;
            prefix_node_clean_reg <= 1'b1;
            prefix_dom_clean_reg  <= 1'b1;
            node_cnt_reg          <= '0;
            node_clean_reg        <= 1'b1;
            dom_cnt_reg           <= '0;
            dom_clean_reg         <= 1'b1;
            res_cnt_reg           <= '0;
            res_clean_reg         <= 1'b1;
        end
        else
        begin
            phase_reg             <= phase_next;
            prefix_len_reg        <= prefix_len_next;
            prefix_node_clean_reg <= prefix_node_clean_next;
            prefix_dom_clean_reg  <= prefix_dom_clean_next;
            node_cnt_reg          <= node_cnt_next;
            node_clean_reg        <= node_clean_next;
            dom_cnt_reg           <= dom_cnt_next;
            dom_clean_reg         <= dom_clean_next;
            res_cnt_reg           <= res_cnt_next;
            res_clean_reg         <= res_clean_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_fire && s1_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_fire && s1_last_reg)
        begin
            verdict_reg <= verdict_next;
        end
    end

    assign res_ch.valid           = out_valid_reg;
    assign res_ch.valid_res       = verdict_reg.valid_res;
    assign res_ch.error_code      = verdict_reg.error_code;
    assign res_ch.has_node        = verdict_reg.has_node;
    assign res_ch.node_length     = verdict_reg.node_length;
    assign res_ch.domain_length   = verdict_reg.domain_length;
    assign res_ch.has_resource    = verdict_reg.has_resource;
    assign res_ch.resource_length = verdict_reg.resource_length;

    `XAV_ASSERT_IMP(a_ok_matches_code, clk, rst_n, out_valid_reg,
        verdict_reg.valid_res == (verdict_reg.error_code == ERR_OK))
    `XAV_ASSERT_IMP(a_fail_zero_lengths, clk, rst_n,
        out_valid_reg && !verdict_reg.valid_res,
        verdict_reg.node_length == '0 && verdict_reg.domain_length == '0 &&
        verdict_reg.resource_length == '0)
    `XAV_ASSERT_IMP(a_ok_domain_min, clk, rst_n, out_valid_reg && verdict_reg.valid_res,
        32'(verdict_reg.domain_length) >= MIN_DOMAIN_UNITS)
    `XAV_ASSERT_NXT(a_state_cleared, clk, rst_n, s1_fire && s1_last_reg,
        phase_reg == PH_PREFIX && prefix_len_reg == '0 && res_cnt_reg == '0)

endmodule
